@@ hdl/rhs_pkg.sv @@
package rhs_pkg;

   localparam int MAX_PATTERN_DEF   = 16;
   localparam int POSITION_BITS_DEF = 32;

   localparam int BYTE_BITS         = 8;
   localparam int WORD_BITS         = 64;
   localparam int LEN_BITS          = 5;
   localparam int RSP_POS_BITS      = 32;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int PATTERN_REG_BYTES = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LEN  = 2'd2;

   // inverse of 3 modulo 2^64, truncates to the inverse modulo any 2^w
   localparam logic [63:0] INV3_FULL = 64'hAAAA_AAAA_AAAA_AAAB;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_HASH_INIT,
      ST_HASH,
      ST_CMP
   } state_type;

   typedef struct packed {
      logic accept;
      logic hash_init;
      logic hash_step;
      logic cmp_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic hash_done;
      logic cmp_mismatch;
      logic cmp_end;
      logic out_free;
   } sts_type;

   // elaboration only
   function automatic logic [63:0] pow3(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd3;
      end
      return p;
   endfunction

   function automatic int hash_bits(input int max_len);
      return $clog2(pow3(max_len));
   endfunction

   // 4^i is 1 mod 3, so the sum of the 2-bit digits keeps the remainder
   function automatic logic [1:0] mod3(input logic [BYTE_BITS-1:0] b);
      logic [3:0] s;
      logic [1:0] r;
      s = 4'(b[7:6]) + 4'(b[5:4]) + 4'(b[3:2]) + 4'(b[1:0]);
      case (s)
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
         4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
         default:                       r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/rhs_ctrl.sv @@
module rhs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             csr_we,
   input  rhs_pkg::sts_type sts,
   output rhs_pkg::cmd_type cmd
);
   import rhs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_ready  = !sts.hit;
            cmd.accept = req_valid && !sts.hit;
            if (sts.hit) begin
               cmd.cmp_start = 1'b1;
               state_in      = ST_CMP;
            end
         end
         ST_HASH_INIT: begin
            cmd.hash_init = 1'b1;
            state_in      = ST_HASH;
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_done) begin
               state_in = ST_RUN;
            end
         end
         ST_CMP: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.cmp_mismatch || sts.cmp_end) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      // any register write restarts the pattern hash
      if (csr_we) begin
         cmd       = '0;
         req_ready = 1'b0;
         state_in  = ST_HASH_INIT;
      end
   end

`ifndef NO_ASSERTIONS
   a_cmp_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP && !(cmd.emit && (sts.cmp_mismatch || sts.cmp_end)) && !csr_we
      |=> state_ff == ST_CMP)
      else $error("compare run left before its last item");

   a_hit_in_run: assert property (@(posedge clock) disable iff (reset)
      sts.hit |-> state_ff == ST_RUN || $past(csr_we))
      else $error("hash hit outside the run state");
`endif

endmodule

@@ hdl/rhs_datapath.sv @@
module rhs_datapath #(
   parameter int MAX_PATTERN   = rhs_pkg::MAX_PATTERN_DEF,
   parameter int POSITION_BITS = rhs_pkg::POSITION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rhs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rhs_pkg::WORD_BITS-1:0]       csr_wdata,
   input  logic [rhs_pkg::BYTE_BITS-1:0]       req_text_byte,
   input  rhs_pkg::cmd_type                    cmd,
   output rhs_pkg::sts_type                    sts,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [rhs_pkg::RSP_POS_BITS-1:0]    rsp_position,
   output logic                                rsp_found,
   output logic                                rsp_last
);
   import rhs_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_PATTERN + 1);
   localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int HB       = hash_bits(MAX_PATTERN);
   localparam logic [HB-1:0] INV3_HB = HB'(INV3_FULL);

   logic [WORD_BITS-1:0]   pattern_low_ff, pattern_high_ff;
   logic [LEN_BITS-1:0]    pattern_len_ff;
   logic [2*WORD_BITS-1:0] pat_vec;

   logic [BYTE_BITS-1:0] pat_byte [MAX_PATTERN];
   logic [HB-1:0]        pow3_tbl [MAX_PATTERN];
   logic [BYTE_BITS-1:0] win_ff   [MAX_PATTERN];
   logic [BYTE_BITS-1:0] win_in   [MAX_PATTERN];
   logic [BYTE_BITS-1:0] win_up   [MAX_PATTERN];

   logic [CNT_BITS-1:0] used_n, n_m1;
   logic [IDX_BITS-1:0] fill_idx, nm1_idx;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                check_ff, check_in;
   logic                filling, len_write, full_match;

   logic [HB-1:0] wh_ff, wh_in, ph_ff, ph_in;
   logic [HB-1:0] term_pow, term, diff, quot;
   logic [1:0]    new_digit, old_digit;

   logic [BYTE_BITS-1:0] cur_win, cur_pat;

   logic [POSITION_BITS-1:0] pos_ff, pos_in, cmp_pos_ff, cmp_pos_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_POS_BITS-1:0] rsp_position_ff;
   logic                    rsp_found_ff, rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         pattern_len_ff  <= LEN_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_wdata;
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_wdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign pat_vec   = {pattern_high_ff, pattern_low_ff};
   assign len_write = csr_we && (csr_index == CSR_PATTERN_LEN);

   always_comb begin
      if (pattern_len_ff == '0) begin
         used_n = CNT_BITS'(1);
      end else if (int'(pattern_len_ff) > MAX_PATTERN) begin
         used_n = CNT_BITS'(MAX_PATTERN);
      end else begin
         used_n = CNT_BITS'(pattern_len_ff);
      end
   end

   assign n_m1     = used_n - CNT_BITS'(1);
   assign nm1_idx  = n_m1[IDX_BITS-1:0];
   assign fill_idx = fill_ff[IDX_BITS-1:0];
   assign filling  = fill_ff < used_n;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_slot
      assign pow3_tbl[k] = HB'(pow3(k));
      if (k < PATTERN_REG_BYTES) begin : g_pat
         assign pat_byte[k] = pat_vec[k*BYTE_BITS +: BYTE_BITS];
      end else begin : g_pat_zero
         assign pat_byte[k] = '0;
      end
      if (k < MAX_PATTERN - 1) begin : g_up
         assign win_up[k] = win_ff[k+1];
      end else begin : g_top
         assign win_up[k] = '0;
      end
   end

   assign cur_win = win_ff[idx_ff];
   assign cur_pat = pat_byte[idx_ff];

   // window bytes: fill at the fill count, else shift down and put the byte on top
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         win_in[k] = win_ff[k];
         if (cmd.accept) begin
            if (filling) begin
               if (fill_idx == IDX_BITS'(k)) begin
                  win_in[k] = req_text_byte;
               end
            end else if (nm1_idx == IDX_BITS'(k)) begin
               win_in[k] = req_text_byte;
            end else if (IDX_BITS'(k) < nm1_idx) begin
               win_in[k] = win_up[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   // rolling hash; removing the oldest digit leaves an exact multiple of 3
   assign new_digit = mod3(req_text_byte);
   assign old_digit = mod3(win_ff[0]);
   assign term_pow  = filling ? pow3_tbl[fill_idx] : pow3_tbl[nm1_idx];
   assign diff      = wh_ff - HB'(old_digit);
   assign quot      = diff * INV3_HB;

   always_comb begin
      case (new_digit)
         2'd1:    term = term_pow;
         2'd2:    term = term_pow << 1;
         default: term = '0;
      endcase
   end

   assign full_match = !sts.cmp_mismatch && sts.cmp_end;

   always_comb begin
      wh_in    = wh_ff;
      fill_in  = fill_ff;
      check_in = cmd.accept && (!filling || (fill_ff + CNT_BITS'(1) == used_n));
      if (len_write || (cmd.emit && full_match)) begin
         wh_in   = '0;
         fill_in = '0;
      end else if (cmd.accept) begin
         if (filling) begin
            wh_in   = wh_ff + term;
            fill_in = fill_ff + CNT_BITS'(1);
         end else begin
            wh_in = quot + term;
         end
      end
   end

   // pattern hash by Horner from the top place down, and compare index
   always_comb begin
      ph_in      = ph_ff;
      idx_in     = idx_ff;
      pos_in     = cmd.accept ? pos_ff + POSITION_BITS'(1) : pos_ff;
      cmp_pos_in = cmp_pos_ff;
      if (cmd.hash_init) begin
         ph_in  = '0;
         idx_in = nm1_idx;
      end else if (cmd.hash_step) begin
         ph_in = (ph_ff << 1) + ph_ff + HB'(mod3(cur_pat));
         if (!sts.hash_done) begin
            idx_in = idx_ff - IDX_BITS'(1);
         end
      end else if (cmd.cmp_start) begin
         idx_in     = '0;
         cmp_pos_in = pos_ff - POSITION_BITS'(used_n) + POSITION_BITS'(1);
      end else if (cmd.emit) begin
         idx_in     = idx_ff + IDX_BITS'(1);
         cmp_pos_in = cmp_pos_ff + POSITION_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wh_ff    <= '0;
         ph_ff    <= '0;
         fill_ff  <= '0;
         check_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         wh_ff    <= wh_in;
         ph_ff    <= ph_in;
         fill_ff  <= fill_in;
         check_ff <= check_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_pos_ff <= cmp_pos_in;
   end

   assign sts.hit          = check_ff && (wh_ff == ph_ff);
   assign sts.hash_done    = idx_ff == '0;
   assign sts.cmp_mismatch = cur_win != cur_pat;
   assign sts.cmp_end      = idx_ff == nm1_idx;
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   // result register
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_position_ff <= RSP_POS_BITS'(cmp_pos_ff);
         rsp_found_ff    <= full_match;
         rsp_last_ff     <= sts.cmp_mismatch || sts.cmp_end;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= used_n)
      else $error("window fill count beyond pattern length");

   a_match_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && full_match |=> fill_ff == '0 && wh_ff == '0)
      else $error("window not emptied after a full match");
`endif

endmodule

@@ hdl/rolling_hash_substring_search.sv @@
// results: a byte that completes a matching-hash window updates the registered hash;
//   a hit then gives up to pattern length results, one per cycle when not stalled
// throughput: one text byte per cycle; input stalls on a hash hit while its results go out
// a register write stalls input while the pattern hash is rebuilt
// reset: synchronous, active high; pattern cleared to length 1, window empty, position zero
module rolling_hash_substring_search #(
   parameter int MAX_PATTERN   = rhs_pkg::MAX_PATTERN_DEF,
   parameter int POSITION_BITS = rhs_pkg::POSITION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rhs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rhs_pkg::WORD_BITS-1:0]      csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rhs_pkg::BYTE_BITS-1:0]      req_text_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rhs_pkg::RSP_POS_BITS-1:0]   rsp_position,
   output logic                               rsp_found,
   output logic                               rsp_last
);
   import rhs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_we    (csr_we),
      .sts       (sts),
      .cmd       (cmd)
   );

   rhs_datapath #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_text_byte (req_text_byte),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_position  (rsp_position),
      .rsp_found     (rsp_found),
      .rsp_last      (rsp_last)
   );

endmodule
